@@ design/rrwm_pkg.sv @@
package rrwm_pkg;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_NEW  = 2'd1;
  localparam logic [1:0] ACT_DEL  = 2'd2;

  localparam logic [2:0] REG_WINDOW    = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_DELAY     = 3'd2;
  localparam logic [2:0] REG_ID_COUNT  = 3'd3;
  localparam logic [2:0] REG_ID_BASE   = 3'd4;

  localparam int BYTES_W = 48;
  localparam int TIME_W  = 32;
  localparam int ID_W    = 17;
  localparam int CFG_W   = 17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // register the input item
    logic rd;         // rule record read state
    logic cap;        // capture rule state, saturate bytes
    logic div_start;  // start the window divider
    logic div_step;   // one quotient bit
    logic mul;        // form both products
    logic decide;     // compare and pick the action
    logic scan_rd;    // read the id bit at the scan pointer
    logic scan_chk;   // examine the returned id bit
    logic commit;     // write rule and id state, present the result
    logic clr;        // clear pass step
  } rrwm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic want_alloc;   // NEW with allocation enabled
    logic scan_done;
    logic clr_done;
  } rrwm_sts_t;

endpackage

@@ design/rule_rate_window_monitor.sv @@
// Channel   | Signals                                          | Handshake
// input     | rule_index now_seconds byte_count rate_limit     | start while !busy
// result    | action rule_id alloc_failed                      | done, one cycle
// config    | cfg_we cfg_index cfg_data                        | write on cfg_we
// An item runs through read, capture, the rate division, the products, the
// decision and the commit, with busy high until the commit. The rate division
// runs one quotient bit a cycle over the 48-bit byte count. A NEW with
// allocation adds a read, a wait and a check per bitmap slot examined through
// the single id RAM port. After reset a clearing pass over max(NUM_RULES,
// NUM_IDS) entries runs with busy high. Results cannot be stalled.
module rule_rate_window_monitor #(
  parameter int NUM_RULES = 256,
  parameter int NUM_IDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  rule_index,
  input  logic [31:0] now_seconds,
  input  logic [15:0] byte_count,
  input  logic [39:0] rate_limit,
  output logic        done,
  output logic [1:0]  action,
  output logic [16:0] rule_id,
  output logic        alloc_failed,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  rrwm_pkg::rrwm_cmd_t cmd;
  rrwm_pkg::rrwm_sts_t sts;

  rrwm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  rrwm_dp #(.NUM_RULES(NUM_RULES), .NUM_IDS(NUM_IDS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .rule_index(rule_index), .now_seconds(now_seconds),
    .byte_count(byte_count), .rate_limit(rate_limit),
    .done(done), .action(action), .rule_id(rule_id),
    .alloc_failed(alloc_failed)
  );
endmodule

@@ design/rrwm_ram.sv @@
module rrwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/rrwm_ctrl.sv @@
module rrwm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output rrwm_pkg::rrwm_cmd_t cmd,
  input  rrwm_pkg::rrwm_sts_t sts
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_CAP   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DEC   = 4'd6;
  localparam logic [3:0] S_SRD   = 4'd7;
  localparam logic [3:0] S_SCHK  = 4'd8;
  localparam logic [3:0] S_COMMIT = 4'd9;
  localparam logic [3:0] S_SWAIT = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.cap = 1'b1;
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_next = sts.want_alloc ? S_SRD : S_COMMIT;
      end
      S_SRD: begin
        cmd.scan_rd = 1'b1;
        state_next = S_SWAIT;
      end
      S_SWAIT: begin
        state_next = S_SCHK;
      end
      S_SCHK: begin
        cmd.scan_chk = 1'b1;
        state_next = sts.scan_done ? S_COMMIT : S_SRD;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ design/rrwm_dp.sv @@
module rrwm_dp #(
  parameter int NUM_RULES = 256,
  parameter int NUM_IDS = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rrwm_pkg::rrwm_cmd_t      cmd,
  output rrwm_pkg::rrwm_sts_t      sts,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [rrwm_pkg::CFG_W-1:0] cfg_data,
  input  logic [7:0]               rule_index,
  input  logic [31:0]              now_seconds,
  input  logic [15:0]              byte_count,
  input  logic [39:0]              rate_limit,
  output logic                     done,
  output logic [1:0]               action,
  output logic [16:0]              rule_id,
  output logic                     alloc_failed
);
  localparam int RA_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int IA_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int CNT_W = $clog2(NUM_IDS + 1);
  localparam int CLR_W = ((RA_W > IA_W) ? RA_W : IA_W) + 1;
  localparam int BW = rrwm_pkg::BYTES_W;
  localparam int TW = rrwm_pkg::TIME_W;
  localparam int IW = rrwm_pkg::ID_W;
  // Rule record: bytes, window start, active, reported time, id.
  localparam int REC_W = BW + TW + 1 + TW + IW;

  // Configuration.
  logic [11:0] window_seconds;
  logic [15:0] threshold_q8;
  logic [16:0] hold_secs;
  logic [10:0] id_count;
  logic [15:0] id_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= 12'd1;
      threshold_q8   <= 16'd205;
      hold_secs      <= 17'd60;
      id_count       <= 11'd1024;
      id_base        <= 16'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrwm_pkg::REG_WINDOW:    window_seconds <= cfg_data[11:0];
        rrwm_pkg::REG_THRESHOLD: threshold_q8 <= cfg_data[15:0];
        rrwm_pkg::REG_DELAY:     hold_secs <= cfg_data[16:0];
        rrwm_pkg::REG_ID_COUNT:  id_count <= cfg_data[10:0];
        rrwm_pkg::REG_ID_BASE:   id_base <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Effective id count, clipped to the bitmap size.
  logic [CNT_W-1:0] eff_n;
  always_comb begin
    if ({21'd0, id_count} > 32'(NUM_IDS)) eff_n = CNT_W'(NUM_IDS);
    else eff_n = CNT_W'(id_count);
  end

  // Item registers.
  logic [7:0]  r_idx;
  logic [TW-1:0] now_r;
  logic [15:0] bytes_r;
  logic [39:0] limit_r;
  logic        in_range;
  logic [RA_W-1:0] raddr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_idx   <= rule_index;
      now_r   <= now_seconds;
      bytes_r <= byte_count;
      limit_r <= rate_limit;
    end
  end
  assign in_range = ({24'd0, r_idx} < 32'(NUM_RULES));
  assign raddr = RA_W'(r_idx);

  // Clear pass over rule and id memories.
  logic [CLR_W-1:0] clr_ptr;
  logic clr_last;
  assign clr_last = (clr_ptr >= CLR_W'(((NUM_RULES > NUM_IDS) ? NUM_RULES : NUM_IDS) - 1));
  always_ff @(posedge clk) begin
    if (rst) clr_ptr <= '0;
    else if (cmd.clr && !clr_last) clr_ptr <= clr_ptr + 1'b1;
  end
  assign sts.clr_done = cmd.clr && clr_last;

  // Rule record memory.
  logic rec_we;
  logic [RA_W-1:0] rec_waddr;
  logic [REC_W-1:0] rec_wdata, rec_rdata;

  rrwm_ram #(.WIDTH(REC_W), .DEPTH(NUM_RULES)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(raddr), .rdata(rec_rdata)
  );

  // Id bitmap memory.
  logic id_we;
  logic [IA_W-1:0] id_waddr, id_raddr;
  logic id_wdata;
  logic [0:0] id_rdata;

  rrwm_ram #(.WIDTH(1), .DEPTH(NUM_IDS)) u_ids (
    .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
    .raddr(id_raddr), .rdata(id_rdata)
  );

  // Captured rule state.
  logic [BW-1:0] wbytes;
  logic [TW-1:0] wstart, rtime;
  logic          active;
  logic [IW-1:0] aid;
  logic          expired;
  logic [11:0]   w_eff;
  assign w_eff = (window_seconds == 12'd0) ? 12'd1 : window_seconds;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      logic [BW:0] sum;
      sum = {1'b0, rec_rdata[REC_W-1 -: BW]} + (BW+1)'(bytes_r);
      wbytes  <= sum[BW] ? {BW{1'b1}} : sum[BW-1:0];
      wstart  <= rec_rdata[REC_W-BW-1 -: TW];
      active  <= rec_rdata[IW+TW];
      rtime   <= rec_rdata[IW+TW-1 -: TW];
      aid     <= rec_rdata[IW-1:0];
      expired <= ({1'b0, now_r} >= ({1'b0, rec_rdata[REC_W-BW-1 -: TW]} + 33'(w_eff)));
    end
  end

  // Restoring divider, one quotient bit a cycle.
  logic [BW-1:0] quo, dvd;
  logic [11:0]   rem;
  logic [5:0]    div_cnt;
  assign sts.div_done = cmd.div_step && (div_cnt == 6'd0);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_cnt <= 6'(BW - 1);
      rem <= '0;
    end else if (cmd.div_step) begin
      logic [12:0] t;
      t = {rem, (div_cnt == 6'(BW - 1)) ? wbytes[BW-1] : dvd[BW-1]};
      if (t >= {1'b0, w_eff}) begin
        rem <= 12'(t - {1'b0, w_eff});
        quo <= {quo[BW-2:0], 1'b1};
      end else begin
        rem <= t[11:0];
        quo <= {quo[BW-2:0], 1'b0};
      end
      div_cnt <= div_cnt - 6'd1;
    end
    if (cmd.div_step) begin
      dvd <= ((div_cnt == 6'(BW - 1)) ? wbytes : dvd) << 1;
    end
  end

  // Products: rate * 2048 = quo << 11, limit * threshold.
  logic [58:0] rate_s;
  logic [55:0] lim_th;
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rate_s <= {quo, 11'd0};
      lim_th <= limit_r * threshold_q8;
    end
  end

  // Decision.
  logic [1:0] act;
  logic       over;
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      over <= (rate_s > 59'(lim_th));
      if (!in_range) act <= rrwm_pkg::ACT_NONE;
      else if (rate_s > 59'(lim_th)) begin
        act <= active ? rrwm_pkg::ACT_NONE : rrwm_pkg::ACT_NEW;
      end else if (active && (({1'b0, rtime} + 33'(hold_secs)) < {1'b0, now_r})
                   && expired) begin
        act <= rrwm_pkg::ACT_DEL;
      end else begin
        act <= rrwm_pkg::ACT_NONE;
      end
    end
  end
  assign sts.want_alloc = in_range && (rate_s > 59'(lim_th)) && !active
                          && (id_count != 11'd0);

  // Round-robin scan.
  logic [IA_W:0] ptr;
  logic [IA_W:0] tries;
  logic          scan_first, found;
  logic [IA_W:0] ptr_eff;
  logic [IA_W:0] ptr_inc;
  assign ptr_eff = (ptr >= (IA_W+1)'(eff_n)) ? '0 : ptr;
  assign ptr_inc = ptr_eff + 1'b1;
  assign id_raddr = cmd.clr ? IA_W'(clr_ptr) : IA_W'(ptr_eff);
  assign sts.scan_done = cmd.scan_chk && (!id_rdata[0] || (tries + 1'b1 > (IA_W+1)'(eff_n)));

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      if (cmd.decide) begin
        tries <= '0;
        found <= 1'b0;
      end
      if (cmd.scan_rd) begin
        ptr <= ptr_eff;
      end
      if (cmd.scan_chk) begin
        if (!id_rdata[0]) begin
          found <= 1'b1;
        end else begin
          // The pointer wraps at the id count as it steps.
          ptr <= (ptr_inc >= (IA_W+1)'(eff_n)) ? '0 : ptr_inc;
          tries <= tries + 1'b1;
        end
      end
    end
  end
  assign scan_first = found;

  // Release slot computation.
  logic [31:0] rel_idx;
  assign rel_idx = {15'd0, aid} - {16'd0, id_base};

  // Commit.
  logic [IW-1:0] new_id;
  logic [IW-1:0] out_id;
  logic          out_fail;
  always_comb begin
    new_id = aid;
    out_fail = 1'b0;
    if (act == rrwm_pkg::ACT_NEW && id_count != 11'd0) begin
      if (scan_first) new_id = IW'(ptr[IA_W-1:0]) + IW'(id_base);
      else begin
        new_id = IW'(id_base);
        out_fail = 1'b1;
      end
    end
    out_id = (act == rrwm_pkg::ACT_NONE) ? '0 : new_id;
  end

  always_comb begin
    logic [BW-1:0] nb;
    logic [TW-1:0] ns, nr;
    logic          na;
    logic [IW-1:0] ni;
    nb = expired ? '0 : wbytes;
    ns = expired ? now_r : wstart;
    na = active;
    nr = rtime;
    ni = aid;
    if (over) nr = now_r;
    if (act == rrwm_pkg::ACT_NEW) begin
      na = 1'b1;
      ni = new_id;
    end else if (act == rrwm_pkg::ACT_DEL) begin
      na = 1'b0;
      nr = '0;
      if (id_count != 11'd0) ni = '0;
    end
    rec_we = (cmd.commit && in_range) || (cmd.clr && clr_ptr < CLR_W'(NUM_RULES));
    rec_waddr = cmd.clr ? RA_W'(clr_ptr) : raddr;
    rec_wdata = cmd.clr ? '0 : {nb, ns, na, nr, ni};

    id_we = 1'b0;
    id_waddr = IA_W'(ptr);
    id_wdata = 1'b0;
    if (cmd.clr) begin
      id_we = (clr_ptr < CLR_W'(NUM_IDS));
      id_waddr = IA_W'(clr_ptr);
    end else if (cmd.commit && act == rrwm_pkg::ACT_NEW && id_count != 11'd0 && scan_first) begin
      id_we = 1'b1;
      id_wdata = 1'b1;
    end else if (cmd.commit && act == rrwm_pkg::ACT_DEL && id_count != 11'd0
                 && rel_idx < 32'(eff_n)) begin
      id_we = 1'b1;
      id_waddr = IA_W'(rel_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
    if (cmd.commit) begin
      action <= act;
      rule_id <= out_id;
      alloc_failed <= out_fail;
    end
  end
endmodule
